/* rtl/core/rpn_pkg.sv */
`default_nettype none
package rpn_pkg;

  localparam int VAL_W           = 48;
  localparam int FUNC_W          = 4;
  localparam int STACK_DEPTH_DEF = 16;
  localparam int FRAC_BITS_DEF   = 16;

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef logic signed [VAL_W-1:0] val_t;

  // token operation codes; code fifteen is unused and does nothing
  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH = 4'd0,
    FN_ADD  = 4'd1,
    FN_SUB  = 4'd2,
    FN_MUL  = 4'd3,
    FN_DIV  = 4'd4,
    FN_EQ   = 4'd5,
    FN_NE   = 4'd6,
    FN_LT   = 4'd7,
    FN_GT   = 4'd8,
    FN_LE   = 4'd9,
    FN_GE   = 4'd10,
    FN_AND  = 4'd11,
    FN_OR   = 4'd12,
    FN_XOR  = 4'd13,
    FN_NOT  = 4'd14
  } func_t;

  // what a stack cell loads this cycle
  typedef enum logic [1:0] {
    CM_HOLD,
    CM_FROM_UP,
    CM_FROM_DOWN
  } cell_mode_t;

  typedef enum logic {
    ST_IDLE,
    ST_BUSY
  } state_t;

  // request to the iterative multiply/divide unit
  typedef struct packed {
    logic start;
    logic is_div;
    val_t a;
    val_t b;
  } md_req_t;

  typedef struct packed {
    logic done;
    val_t result;
  } md_rsp_t;

endpackage
`default_nettype wire

/* rtl/core/rpn_tok_if.sv */
`default_nettype none
interface rpn_tok_if import rpn_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic signed [VAL_W-1:0] operand;
  logic              last;

  modport source (output valid, func, operand, last, input ready);
  modport sink   (input valid, func, operand, last, output ready);
endinterface
`default_nettype wire

/* rtl/core/rpn_res_if.sv */
`default_nettype none
interface rpn_res_if import rpn_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] value;
  logic                    underflow;
  logic                    overflow;
  logic                    div_by_zero;

  modport source (output valid, value, underflow, overflow, div_by_zero, input ready);
  modport sink   (input valid, value, underflow, overflow, div_by_zero, output ready);
endinterface
`default_nettype wire

/* rtl/core/rpn_cell.sv */
`default_nettype none
module rpn_cell import rpn_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cell_mode_t mode,
  input  wire val_t       up_val,
  input  wire val_t       down_val,
  output val_t            val
);

  // load from a neighbour or hold
  always_ff @(posedge clk) begin
    if (rst) begin
      val <= '0;
    end else begin
      unique case (mode)
        CM_FROM_UP:   val <= up_val;
        CM_FROM_DOWN: val <= down_val;
        default:      val <= val;
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/core/rpn_muldiv.sv */
`default_nettype none
module rpn_muldiv import rpn_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire md_req_t req,
  output md_rsp_t      rsp
);

  localparam int NW    = VAL_W + FRAC_BITS;
  localparam int PW    = 2 * VAL_W;
  localparam int CNT_W = $clog2(NW + 1);

  logic             busy;
  logic             is_div;
  logic             neg;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [PW-1:0]    acc;
  logic [PW-1:0]    mc;
  logic [VAL_W-1:0] mp;
  logic [NW-1:0]    num;
  logic [VAL_W:0]   rem;
  logic [VAL_W-1:0] dvs;

  logic [VAL_W-1:0] mag_a;
  logic [VAL_W-1:0] mag_b;
  logic [VAL_W:0]   rem_sh;
  logic             q_bit;
  logic [PW-1:0]    mag_res;
  logic [VAL_W-1:0] mag_lo;

  assign mag_a  = req.a[VAL_W-1] ? VAL_W'(-req.a) : VAL_W'(req.a);
  assign mag_b  = req.b[VAL_W-1] ? VAL_W'(-req.b) : VAL_W'(req.b);
  assign rem_sh = {rem[VAL_W-1:0], num[NW-1]};
  assign q_bit  = rem_sh >= {1'b0, dvs};

  // one multiplier bit or one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy   <= 1'b1;
        is_div <= req.is_div;
        neg    <= req.a[VAL_W-1] ^ req.b[VAL_W-1];
        cnt    <= req.is_div ? CNT_W'(NW) : CNT_W'(VAL_W);
        acc    <= '0;
        mc     <= PW'(mag_a);
        mp     <= mag_b;
        num    <= NW'(mag_a) << FRAC_BITS;
        rem    <= '0;
        dvs    <= mag_b;
      end else if (busy) begin
        if (is_div) begin
          rem <= q_bit ? rem_sh - {1'b0, dvs} : rem_sh;
          num <= {num[NW-2:0], q_bit};
        end else begin
          if (mp[0]) acc <= acc + mc;
          mc <= mc << 1;
          mp <= mp >> 1;
        end
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // scale, restore sign and saturate
  assign mag_res = is_div ? PW'(num) : acc >> FRAC_BITS;
  assign mag_lo  = mag_res[VAL_W-1:0];

  always_comb begin
    rsp.done = done;
    if (neg) begin
      if (mag_res >= PW'({1'b1, {(VAL_W-1){1'b0}}})) rsp.result = VAL_MIN;
      else rsp.result = val_t'(~mag_lo + VAL_W'(1));
    end else begin
      if (mag_res > PW'(VAL_MAX)) rsp.result = VAL_MAX;
      else rsp.result = val_t'(mag_lo);
    end
  end

endmodule
`default_nettype wire

/* rtl/core/rpn_stack_evaluator_unit.sv */
// Postfix expression evaluator on a stack of signed Q31.16 numbers.
// Tokens enter on the tok channel (func, operand, last) and a result leaves
// on the res channel (value and sticky underflow, overflow, div_by_zero
// flags) once for every token marked last; other tokens give no result.
// The stack is a row of cells; push shifts every cell down by one, a binary
// operator writes the top cell and shifts the cells below it up by one.
// Push, add, sub, comparison and bitwise tokens execute when accepted; the
// result of such a last token is valid the cycle after it is accepted.
// Multiply and divide run in the shared shift-add / restoring divide unit
// (one bit a cycle); tok.ready stays low meanwhile, so the next token is
// taken only after the unit has finished.
// Division by zero saturates without using the unit.
// Throughput: one token a cycle for operations that do not use the unit.
// A finished result waits in an output register; while it is not taken,
// tok.ready stays low and no further token is accepted.
// Reset (synchronous, active high) leaves a single zero on the stack and
// clears the flags; no clearing pass is needed.
`default_nettype none
module rpn_stack_evaluator_unit import rpn_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input wire logic   clk,
  input wire logic   rst,
  rpn_tok_if.sink    tok,
  rpn_res_if.source  res
);

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam val_t ONE = val_t'(64'(1) << FRAC_BITS);

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             err_under;
  logic             err_over;
  logic             err_div;
  logic             err_under_next;
  logic             err_over_next;
  logic             err_div_next;
  func_t            sv_func;
  logic             sv_last;

  logic             o_valid;
  val_t             o_value;
  logic             o_under;
  logic             o_over;
  logic             o_div;

  val_t             cell_val [STACK_DEPTH];
  cell_mode_t       cell_mode [STACK_DEPTH];
  val_t             top_in;

  md_req_t          md_req;
  md_rsp_t          md_rsp;

  logic             accept;
  logic             exec;
  logic             use_unit;
  func_t            f;
  logic             lst;
  val_t             a_val;
  val_t             b_val;
  logic             bin_under;
  logic             div_zero;
  val_t             r;
  logic [VAL_W:0]   sum;
  logic [VAL_W:0]   dif;
  logic             push_full;
  logic [CNT_W-1:0] cnt_after;
  val_t             top_after;

  function automatic val_t int_part(input val_t x);
    logic [VAL_W-1:0] m;
    logic [VAL_W-1:0] ip;
    m  = x[VAL_W-1] ? VAL_W'(-x) : VAL_W'(x);
    ip = m >> FRAC_BITS;
    return x[VAL_W-1] ? val_t'(-ip) : val_t'(ip);
  endfunction

  function automatic val_t from_int(input val_t i);
    return i << FRAC_BITS;
  endfunction

  // operands from the two top cells, zero where the stack runs dry
  assign f         = (state == ST_BUSY) ? sv_func : func_t'(tok.func);
  assign lst       = (state == ST_BUSY) ? sv_last : tok.last;
  assign b_val     = (count >= CNT_W'(1)) ? cell_val[0] : '0;
  assign a_val     = (count >= CNT_W'(2)) ? cell_val[1] : '0;
  assign bin_under = count < CNT_W'(2);
  assign div_zero  = (f == FN_DIV) && (b_val == '0);
  assign sum       = {a_val[VAL_W-1], a_val} + {b_val[VAL_W-1], b_val};
  assign dif       = {a_val[VAL_W-1], a_val} - {b_val[VAL_W-1], b_val};
  assign push_full = count >= CNT_W'(STACK_DEPTH);

  assign tok.ready = (state == ST_IDLE) && (!o_valid || res.ready);
  assign accept    = tok.valid && tok.ready;
  assign use_unit  = (f == FN_MUL) || ((f == FN_DIV) && !div_zero);
  assign exec      = (accept && !use_unit) || md_rsp.done;

  assign md_req.start  = accept && use_unit;
  assign md_req.is_div = f == FN_DIV;
  assign md_req.a      = a_val;
  assign md_req.b      = b_val;

  rpn_muldiv #(.FRAC_BITS(FRAC_BITS)) u_muldiv (
    .clk (clk),
    .rst (rst),
    .req (md_req),
    .rsp (md_rsp)
  );

  // result of the current token
  always_comb begin
    unique case (f)
      FN_PUSH: r = tok.operand;
      FN_ADD:  r = (sum[VAL_W] != sum[VAL_W-1]) ? (sum[VAL_W] ? VAL_MIN : VAL_MAX)
                                                 : sum[VAL_W-1:0];
      FN_SUB:  r = (dif[VAL_W] != dif[VAL_W-1]) ? (dif[VAL_W] ? VAL_MIN : VAL_MAX)
                                                 : dif[VAL_W-1:0];
      FN_MUL:  r = md_rsp.result;
      FN_DIV:  r = div_zero ? (a_val[VAL_W-1] ? VAL_MIN : VAL_MAX) : md_rsp.result;
      FN_EQ:   r = (a_val == b_val) ? ONE : '0;
      FN_NE:   r = (a_val != b_val) ? ONE : '0;
      FN_LT:   r = (a_val <  b_val) ? ONE : '0;
      FN_GT:   r = (a_val >  b_val) ? ONE : '0;
      FN_LE:   r = (a_val <= b_val) ? ONE : '0;
      FN_GE:   r = (a_val >= b_val) ? ONE : '0;
      FN_AND:  r = from_int(int_part(a_val) & int_part(b_val));
      FN_OR:   r = from_int(int_part(a_val) | int_part(b_val));
      FN_XOR:  r = from_int(int_part(a_val) ^ int_part(b_val));
      FN_NOT:  r = from_int(~int_part(b_val));
      default: r = '0;
    endcase
  end

  // stack movement, count and flags after the token
  always_comb begin
    cnt_after      = count;
    top_after      = cell_val[0];
    err_under_next = err_under;
    err_over_next  = err_over;
    err_div_next   = err_div;
    top_in         = r;
    for (int i = 0; i < STACK_DEPTH; i++) cell_mode[i] = CM_HOLD;
    if (exec) begin
      priority case (f)
        FN_PUSH: begin
          if (push_full) begin
            err_over_next = 1'b1;
          end else begin
            for (int i = 0; i < STACK_DEPTH; i++) cell_mode[i] = CM_FROM_UP;
            cnt_after = count + CNT_W'(1);
            top_after = r;
          end
        end
        FN_NOT: begin
          cell_mode[0] = CM_FROM_UP;
          top_after    = r;
          if (count == '0) begin
            err_under_next = 1'b1;
            cnt_after      = CNT_W'(1);
          end
        end
        FN_ADD, FN_SUB, FN_MUL, FN_DIV, FN_EQ, FN_NE, FN_LT, FN_GT,
        FN_LE, FN_GE, FN_AND, FN_OR, FN_XOR: begin
          cell_mode[0] = CM_FROM_UP;
          for (int i = 1; i < STACK_DEPTH; i++) cell_mode[i] = CM_FROM_DOWN;
          top_after = r;
          if (div_zero) err_div_next = 1'b1;
          if (bin_under) begin
            err_under_next = 1'b1;
            cnt_after      = CNT_W'(1);
          end else begin
            cnt_after = count - CNT_W'(1);
          end
        end
        default: ;
      endcase
      if (cnt_after == '0) begin
        err_under_next = 1'b1;
        top_after      = '0;
      end
    end
    count_next = cnt_after;
    // last token: start a fresh expression holding one zero
    if (exec && lst) begin
      for (int i = 1; i < STACK_DEPTH; i++) cell_mode[i] = CM_HOLD;
      cell_mode[0] = CM_FROM_UP;
      top_in       = '0;
      count_next   = CNT_W'(1);
    end
  end

  // row of stack cells
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    val_t up_v;
    val_t down_v;
    if (i == 0) begin : g_top
      assign up_v = top_in;
    end else begin : g_mid
      assign up_v = cell_val[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_bot
      assign down_v = '0;
    end else begin : g_inner
      assign down_v = cell_val[i+1];
    end
    rpn_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .mode     (cell_mode[i]),
      .up_val   (up_v),
      .down_val (down_v),
      .val      (cell_val[i])
    );
  end

  // next state
  always_comb begin
    unique case (state)
      ST_IDLE: state_next = md_req.start ? ST_BUSY : ST_IDLE;
      ST_BUSY: state_next = md_rsp.done ? ST_IDLE : ST_BUSY;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= CNT_W'(1);
      err_under <= 1'b0;
      err_over  <= 1'b0;
      err_div   <= 1'b0;
      o_valid   <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (exec && lst) begin
        err_under <= 1'b0;
        err_over  <= 1'b0;
        err_div   <= 1'b0;
      end else begin
        err_under <= err_under_next;
        err_over  <= err_over_next;
        err_div   <= err_div_next;
      end
      if (exec && lst) o_valid <= 1'b1;
      else if (res.ready) o_valid <= 1'b0;
    end
  end

  // hold the token that waits on the unit; load the result register
  always_ff @(posedge clk) begin
    if (md_req.start) begin
      sv_func <= f;
      sv_last <= tok.last;
    end
    if (exec && lst) begin
      o_value <= top_after;
      o_under <= err_under_next;
      o_over  <= err_over_next;
      o_div   <= err_div_next;
    end
  end

  assign res.valid       = o_valid;
  assign res.value       = o_value;
  assign res.underflow   = o_under;
  assign res.overflow    = o_over;
  assign res.div_by_zero = o_div;

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != '0 && count <= CNT_W'(STACK_DEPTH))
    else $error("stack count out of range");

  a_done_in_busy: assert property (@(posedge clk) disable iff (rst)
    md_rsp.done |-> state == ST_BUSY)
    else $error("unit finished outside a pending operation");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state == ST_BUSY |-> !tok.ready)
    else $error("token taken while the unit is busy");

  a_result_free: assert property (@(posedge clk) disable iff (rst)
    (exec && lst) |-> (!o_valid || res.ready))
    else $error("result register overwritten");

endmodule
`default_nettype wire
